@@ hw/rtl/sbb_pkg.sv @@
// sbb_pkg: shared types, codes and letter mapping for the six-bit payload bit buffer
// request and result structs, operation and status codes, armoring helpers
// no dependencies
package sbb_pkg;

  // default sizes, handed to the top level parameters
  localparam int unsigned MAX_BITS_DEF       = 1024;
  localparam int unsigned MAX_TEXT_CHARS_DEF = 63;

  // width of a bit position (bit_start plus text offset, letter ends)
  localparam int unsigned POS_W = 12;

  // operation codes
  typedef enum logic [2:0] {
    OP_WR_LETTER   = 3'd0,
    OP_RD_LETTER   = 3'd1,
    OP_RD_UNSIGNED = 3'd2,
    OP_RD_SIGNED   = 3'd3,
    OP_RD_TEXT     = 3'd4,
    OP_CLEAR       = 3'd5
  } op_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_REFUSED = 2'd1,
    ST_BAD_LEN = 2'd2
  } status_e;

  // one request
  typedef struct packed {
    logic [2:0] operation;
    logic [9:0] bit_start;
    logic [8:0] field_len;
    logic [7:0] letter_pos;
    logic [6:0] letter_in;
  } sbb_req_t;

  // one result
  typedef struct packed {
    logic signed [32:0] value;
    logic [6:0]         char_out;
    logic               last;
    logic [1:0]         status;
    logic [10:0]        bits_used;
  } sbb_rsp_t;

  // byte memory command
  typedef struct packed {
    logic       en;
    logic       we;
    logic [7:0] wdata;
  } ram_cmd_t;

  // armored ascii character to six-bit code, wrapping outside the alphabet
  function automatic logic [5:0] armor_to_code(logic [6:0] c);
    logic [6:0] t;
    t = (c >= 7'd96) ? (c - 7'd56) : (c - 7'd48);
    return t[5:0];
  endfunction

  // six-bit code to armored ascii character
  function automatic logic [6:0] code_to_armor(logic [5:0] code);
    return (code < 6'd40) ? (7'(code) + 7'd48) : (7'(code) + 7'd56);
  endfunction

endpackage

@@ hw/rtl/sbb_ram.sv @@
// sbb_ram: single-port byte memory holding the payload bit string
// one access per cycle, registered read data
// depends on sbb_pkg
module sbb_ram #(
  parameter int unsigned DEPTH = (sbb_pkg::MAX_BITS_DEF + 7) / 8
) (
  input  logic                     clk_i,
  input  sbb_pkg::ram_cmd_t        cmd_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  output logic [7:0]               rdata_o
);
  import sbb_pkg::*;

  logic [7:0] mem_q [DEPTH];

  // write or registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.en) begin
      if (cmd_i.we) begin
        mem_q[addr_i] <= cmd_i.wdata;
      end else begin
        rdata_o <= mem_q[addr_i];
      end
    end
  end

endmodule

@@ hw/rtl/sbb_engine.sv @@
// sbb_engine: sequencer that fetches, merges and writes back payload bytes
// one byte access per cycle, field extraction, text walk and used-bit count
// depends on sbb_pkg
module sbb_engine #(
  parameter int unsigned MAX_BITS       = sbb_pkg::MAX_BITS_DEF,
  parameter int unsigned MAX_TEXT_CHARS = sbb_pkg::MAX_TEXT_CHARS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   req_valid_i,
  output logic                                   req_stall_o,
  input  sbb_pkg::sbb_req_t                      req_i,
  output logic                                   rsp_valid_o,
  input  logic                                   rsp_ready_i,
  output sbb_pkg::sbb_rsp_t                      rsp_o,
  output sbb_pkg::ram_cmd_t                      ram_cmd_o,
  output logic [$clog2((MAX_BITS+7)/8)-1:0]      ram_addr_o,
  input  logic [7:0]                             ram_rdata_i
);
  import sbb_pkg::*;

  localparam int unsigned DEPTH  = (MAX_BITS + 7) / 8;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned BYTE_W = POS_W - 3;
  localparam int unsigned K_W    = $clog2(MAX_TEXT_CHARS + 1);

  typedef enum logic [2:0] {
    S_CLR, S_IDLE, S_FETCH, S_LAST, S_WR_RD, S_WR_WB, S_RESP
  } state_e;

  typedef struct packed {
    logic [BYTE_W-1:0] first;
    logic [2:0]        nb;
    logic [5:0]        sh;
  } fetch_t;

  // byte span and final right shift for a field at position p of length l
  function automatic fetch_t plan(logic [POS_W-1:0] p, logic [5:0] l);
    logic [5:0] span;
    fetch_t     f;
    span    = 6'(p[2:0]) + l - 6'd1;
    f.first = p[POS_W-1:3];
    f.nb    = 3'(span >> 3) + 3'd1;
    f.sh    = 6'({f.nb, 3'b000}) - 6'(p[2:0]) - l;
    return f;
  endfunction

  function automatic sbb_rsp_t mk_rsp(logic [32:0] v, logic [6:0] ch, logic lst,
                                      status_e st, logic [10:0] used);
    sbb_rsp_t r;
    r.value     = v;
    r.char_out  = ch;
    r.last      = lst;
    r.status    = st;
    r.bits_used = used;
    return r;
  endfunction

  state_e             state_q, state_d;
  logic [ADDR_W-1:0]  clr_q, clr_d;
  logic [10:0]        count_q, count_d;
  op_e                op_q, op_d;
  logic [POS_W-1:0]   start_q, start_d;
  logic [9:0]         off_q, off_d;
  logic [8:0]         len_q, len_d;
  logic [K_W-1:0]     k_q, k_d;
  logic [BYTE_W-1:0]  byte_q, byte_d;
  logic [2:0]         left_q, left_d;
  logic [5:0]         sh_q, sh_d;
  logic [5:0]         elen_q, elen_d;
  logic               pend_q, pend_d;
  logic               oob_q, oob_d;
  logic [39:0]        win_q, win_d;
  logic [15:0]        wbits_q, wbits_d;
  logic [15:0]        wmask_q, wmask_d;
  logic               two_q, two_d;
  logic               sec_q, sec_d;
  logic               cont_q, cont_d;
  sbb_rsp_t           rsp_q, rsp_d;

  // extraction datapath
  logic [7:0]  rd_byte;
  logic [39:0] win_full;
  logic [39:0] win_sh;
  logic [32:0] low_mask;
  logic [31:0] field;
  logic        sign_bit;
  logic [5:0]  keep;

  assign rd_byte  = oob_q ? 8'h00 : ram_rdata_i;
  assign win_full = pend_q ? {win_q[31:0], rd_byte} : win_q;
  assign win_sh   = win_full >> sh_q;
  assign low_mask = ~(33'h1_FFFF_FFFF << elen_q);
  assign field    = win_sh[31:0] & low_mask[31:0];
  assign sign_bit = field[5'(elen_q - 6'd1)];

  // letter bits at or past the used count read as zero
  always_comb begin
    for (int i = 0; i < 6; i++) begin
      keep[5-i] = (13'(start_q) + 13'(i)) < 13'(count_q);
    end
  end

  // sequencer
  always_comb begin
    logic [POS_W-1:0] base;
    logic [POS_W-1:0] endp;
    logic [POS_W-1:0] wend;
    logic [5:0]       code;
    logic [5:0]       c;
    logic [7:0]       m;
    logic [7:0]       b;
    logic [10:0]      nc;
    fetch_t           f;

    state_d  = state_q;
    clr_d    = clr_q;
    count_d  = count_q;
    op_d     = op_q;
    start_d  = start_q;
    off_d    = off_q;
    len_d    = len_q;
    k_d      = k_q;
    byte_d   = byte_q;
    left_d   = left_q;
    sh_d     = sh_q;
    elen_d   = elen_q;
    pend_d   = 1'b0;
    oob_d    = oob_q;
    win_d    = win_full;
    wbits_d  = wbits_q;
    wmask_d  = wmask_q;
    two_d    = two_q;
    sec_d    = sec_q;
    cont_d   = cont_q;
    rsp_d    = rsp_q;

    req_stall_o = 1'b1;
    rsp_valid_o = 1'b0;
    ram_cmd_o   = '0;
    ram_addr_o  = ADDR_W'(byte_q);

    base = POS_W'(req_i.letter_pos) * POS_W'(6);
    endp = base + POS_W'(6);
    wend = start_q + POS_W'(6);
    code = armor_to_code(req_i.letter_in);
    c    = field[5:0];
    m    = sec_q ? wmask_q[7:0] : wmask_q[15:8];
    b    = sec_q ? wbits_q[7:0] : wbits_q[15:8];
    nc   = (12'(count_q) < wend) ? 11'(wend) : count_q;
    f    = plan(start_q + POS_W'(off_q), 6'd6);

    unique case (state_q)
      // zero the memory after reset
      S_CLR: begin
        ram_cmd_o  = '{en: 1'b1, we: 1'b1, wdata: 8'h00};
        ram_addr_o = clr_q;
        clr_d      = clr_q + ADDR_W'(1);
        if (clr_q == ADDR_W'(DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end

      // take a request and decode it
      S_IDLE: begin
        req_stall_o = 1'b0;
        if (req_valid_i) begin
          op_d = op_e'(req_i.operation);
          unique case (op_e'(req_i.operation)) inside
            OP_WR_LETTER: begin
              if (32'(endp) > MAX_BITS) begin
                rsp_d   = mk_rsp('0, '0, 1'b1, ST_REFUSED, count_q);
                state_d = S_RESP;
              end else begin
                start_d = base;
                wbits_d = {code, 10'b0} >> base[2:0];
                wmask_d = 16'hFC00 >> base[2:0];
                two_d   = base[2:0] > 3'd2;
                sec_d   = 1'b0;
                byte_d  = base[POS_W-1:3];
                state_d = S_WR_RD;
              end
            end
            OP_RD_LETTER: begin
              f       = plan(base, 6'd6);
              start_d = base;
              elen_d  = 6'd6;
              byte_d  = f.first;
              left_d  = f.nb;
              sh_d    = f.sh;
              state_d = S_FETCH;
            end
            OP_RD_UNSIGNED, OP_RD_SIGNED: begin
              if (req_i.field_len == 9'd0 || req_i.field_len > 9'd32) begin
                rsp_d   = mk_rsp('0, '0, 1'b1, ST_BAD_LEN, count_q);
                state_d = S_RESP;
              end else begin
                f       = plan(POS_W'(req_i.bit_start), req_i.field_len[5:0]);
                elen_d  = req_i.field_len[5:0];
                byte_d  = f.first;
                left_d  = f.nb;
                sh_d    = f.sh;
                state_d = S_FETCH;
              end
            end
            OP_RD_TEXT: begin
              start_d = POS_W'(req_i.bit_start);
              len_d   = req_i.field_len;
              off_d   = '0;
              k_d     = '0;
              if (req_i.field_len == 9'd0) begin
                rsp_d   = mk_rsp('0, '0, 1'b1, ST_OK, count_q);
                state_d = S_RESP;
              end else begin
                f       = plan(POS_W'(req_i.bit_start), 6'd6);
                elen_d  = 6'd6;
                byte_d  = f.first;
                left_d  = f.nb;
                sh_d    = f.sh;
                state_d = S_FETCH;
              end
            end
            OP_CLEAR: begin
              count_d = '0;
              rsp_d   = mk_rsp('0, '0, 1'b1, ST_OK, 11'd0);
              state_d = S_RESP;
            end
            default: begin
              rsp_d   = mk_rsp('0, '0, 1'b1, ST_OK, count_q);
              state_d = S_RESP;
            end
          endcase
        end
      end

      // read the spanned bytes one per cycle
      S_FETCH: begin
        ram_cmd_o  = '{en: 1'b1, we: 1'b0, wdata: 8'h00};
        ram_addr_o = ADDR_W'(byte_q);
        oob_d      = 32'(byte_q) >= DEPTH;
        pend_d     = 1'b1;
        byte_d     = byte_q + BYTE_W'(1);
        left_d     = left_q - 3'd1;
        if (left_q == 3'd1) begin
          state_d = S_LAST;
        end
      end

      // last byte arrives, shape the result
      S_LAST: begin
        state_d = S_RESP;
        unique case (op_q)
          OP_RD_LETTER: begin
            rsp_d = mk_rsp(33'(field[5:0] & keep), code_to_armor(field[5:0] & keep),
                           1'b1, ST_OK, count_q);
          end
          OP_RD_UNSIGNED: begin
            rsp_d = mk_rsp({1'b0, field}, '0, 1'b1, ST_OK, count_q);
          end
          OP_RD_SIGNED: begin
            if (sign_bit) begin
              rsp_d = mk_rsp({1'b1, field | ~low_mask[31:0]}, '0, 1'b1, ST_OK, count_q);
            end else begin
              rsp_d = mk_rsp({1'b0, field}, '0, 1'b1, ST_OK, count_q);
            end
          end
          OP_RD_TEXT: begin
            if (c == 6'd0) begin
              rsp_d = mk_rsp('0, '0, 1'b1, ST_OK, count_q);
            end else begin
              rsp_d  = mk_rsp('0, c[5] ? {1'b0, c} : {1'b1, c}, 1'b0, ST_OK, count_q);
              off_d  = off_q + 10'd6;
              k_d    = k_q + K_W'(1);
              cont_d = ((11'(off_q) + 11'd6) < 11'(len_q)) &&
                       ((32'(k_q) + 32'd1) < MAX_TEXT_CHARS);
            end
          end
          default: begin
            rsp_d = mk_rsp('0, '0, 1'b1, ST_OK, count_q);
          end
        endcase
      end

      // read the byte to merge into
      S_WR_RD: begin
        ram_cmd_o = '{en: 1'b1, we: 1'b0, wdata: 8'h00};
        state_d   = S_WR_WB;
      end

      // merge the letter bits and write back
      S_WR_WB: begin
        ram_cmd_o = '{en: 1'b1, we: 1'b1, wdata: (ram_rdata_i & ~m) | (b & m)};
        if (two_q && !sec_q) begin
          sec_d   = 1'b1;
          byte_d  = byte_q + BYTE_W'(1);
          state_d = S_WR_RD;
        end else begin
          count_d = nc;
          rsp_d   = mk_rsp('0, '0, 1'b1, ST_OK, nc);
          state_d = S_RESP;
        end
      end

      // hand the result over, continue a text walk
      S_RESP: begin
        rsp_valid_o = 1'b1;
        if (rsp_ready_i) begin
          if (rsp_q.last) begin
            state_d = S_IDLE;
          end else if (cont_q) begin
            byte_d  = f.first;
            left_d  = f.nb;
            sh_d    = f.sh;
            state_d = S_FETCH;
          end else begin
            rsp_d = mk_rsp('0, '0, 1'b1, ST_OK, count_q);
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign rsp_o = rsp_q;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      clr_q   <= '0;
      count_q <= '0;
      pend_q  <= 1'b0;
      cont_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      count_q <= count_d;
      pend_q  <= pend_d;
      cont_q  <= cont_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    start_q <= start_d;
    off_q   <= off_d;
    len_q   <= len_d;
    k_q     <= k_d;
    byte_q  <= byte_d;
    left_q  <= left_d;
    sh_q    <= sh_d;
    elen_q  <= elen_d;
    oob_q   <= oob_d;
    win_q   <= win_d;
    wbits_q <= wbits_d;
    wmask_q <= wmask_d;
    two_q   <= two_d;
    sec_q   <= sec_d;
    rsp_q   <= rsp_d;
  end

  // used count never passes capacity
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= MAX_BITS)
    else $error("used bit count beyond capacity");

  // letter write-back stays inside the memory
  a_wb_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_cmd_o.we && state_q != S_CLR) |-> (32'(byte_q) < DEPTH))
    else $error("letter write-back outside memory");

  // extraction length is 1 to 32 when the result is shaped
  a_elen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LAST) |-> (elen_q != 6'd0 && elen_q <= 6'd32))
    else $error("bad extraction length");

  // a delivered last result frees the engine
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RESP && rsp_ready_i && rsp_q.last) |=> (state_q == S_IDLE))
    else $error("engine busy after last result");

endmodule

@@ hw/rtl/six_bit_payload_bit_buffer.sv @@
// Six-bit payload bit buffer top level: byte memory, sequencer, output register; uses sbb_pkg.
// Numeric and letter reads fetch each stored byte that the field spans (one to five), then
// shape the result; a letter write reads, merges and writes back one or two stored bytes.
// Text fetches one or two bytes per character and gives one character at a time; one item
// at a time, the next taken the cycle after the last result leaves the sequencer.
// After reset the memory is zeroed, with in_stall_o high.
module six_bit_payload_bit_buffer #(
  parameter int unsigned MAX_BITS       = sbb_pkg::MAX_BITS_DEF,
  parameter int unsigned MAX_TEXT_CHARS = sbb_pkg::MAX_TEXT_CHARS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  sbb_pkg::sbb_req_t in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output sbb_pkg::sbb_rsp_t out_rsp_o
);
  import sbb_pkg::*;

  localparam int unsigned DEPTH  = (MAX_BITS + 7) / 8;
  localparam int unsigned ADDR_W = $clog2(DEPTH);

  ram_cmd_t          ram_cmd;
  logic [ADDR_W-1:0] ram_addr;
  logic [7:0]        ram_rdata;
  logic              rsp_valid;
  logic              rsp_ready;
  sbb_rsp_t          rsp;
  logic              out_valid_q;
  sbb_rsp_t          out_q;

  sbb_ram #(
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .cmd_i   (ram_cmd),
    .addr_i  (ram_addr),
    .rdata_o (ram_rdata)
  );

  sbb_engine #(
    .MAX_BITS       (MAX_BITS),
    .MAX_TEXT_CHARS (MAX_TEXT_CHARS)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (in_valid_i),
    .req_stall_o (in_stall_o),
    .req_i       (in_req_i),
    .rsp_valid_o (rsp_valid),
    .rsp_ready_i (rsp_ready),
    .rsp_o       (rsp),
    .ram_cmd_o   (ram_cmd),
    .ram_addr_o  (ram_addr),
    .ram_rdata_i (ram_rdata)
  );

  // output register takes a result when empty or draining
  assign rsp_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (rsp_ready) begin
      out_valid_q <= rsp_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp_ready && rsp_valid) begin
      out_q <= rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule
